// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // Default geometry of the console and depth of the attribute stack.
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int STACK_DEPTH_DEF = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Field widths fixed by the interface.
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int COLOR_W = 4;
  localparam int IDX_W  = 11;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

  // Character and attribute constants.
  localparam logic [BYTE_W-1:0] CH_RETURN   = 8'd13;
  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BLANK    = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [BYTE_W-1:0] ZERO_ATTR   = 8'h00;

  // Classified operations handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_RETURN,
    OP_NEWLINE,
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_READ
  } op_t;

  // One queued operation: data is the character for a write and the
  // packed attribute for a push.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  // Sequencer states of the back end.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_POP,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

// ----- src/tcw_front.sv -----
`timescale 1ns / 1ps

module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]    in_command,
  input  logic [tcw_pkg::BYTE_W-1:0]   in_char_code,
  input  logic [tcw_pkg::COLOR_W-1:0]  in_fore_color,
  input  logic [tcw_pkg::COLOR_W-1:0]  in_back_color,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         q_full,
  input  logic                         init_busy,
  output logic                         q_push,
  output tcw_pkg::cmd_t                q_cmd
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  logic                        mono_r;
  logic                        idx_ok;
  logic [tcw_pkg::BYTE_W-1:0]  push_attr;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mono_r <= cfg_data;
    end
  end

  // Items enter the queue when it has room and the screen is not being initialized.
  assign in_ready = !q_full && !init_busy;
  assign q_push   = in_valid && in_ready;

  // A read beyond the screen returns zeros, so it becomes a no-op.
  assign idx_ok = ({21'd0, in_cell_index} < 32'(CELL_COUNT));

  // Attribute for a push: color packing or the monochrome rule.
  always_comb begin
    if (mono_r) begin
      push_attr = (in_fore_color == in_back_color) ? tcw_pkg::ZERO_ATTR
                                                   : tcw_pkg::RESET_ATTR;
    end else begin
      push_attr = {in_back_color, in_fore_color};
    end
  end

  // Classify the incoming item into one back-end operation.
  always_comb begin
    q_cmd.op   = tcw_pkg::OP_NOP;
    q_cmd.data = in_char_code;
    q_cmd.idx  = in_cell_index;
    case (in_command)
      tcw_pkg::CMD_PUT_CHAR: begin
        if (in_char_code >= tcw_pkg::ASCII_LIMIT) begin
          q_cmd.op = tcw_pkg::OP_NOP;
        end else if (in_char_code == tcw_pkg::CH_RETURN) begin
          q_cmd.op = tcw_pkg::OP_RETURN;
        end else if (in_char_code == tcw_pkg::CH_NEWLINE) begin
          q_cmd.op = tcw_pkg::OP_NEWLINE;
        end else begin
          q_cmd.op = tcw_pkg::OP_WRITE;
        end
      end
      tcw_pkg::CMD_PUSH: begin
        q_cmd.op   = tcw_pkg::OP_PUSH;
        q_cmd.data = push_attr;
      end
      tcw_pkg::CMD_POP: begin
        q_cmd.op = tcw_pkg::OP_POP;
      end
      tcw_pkg::CMD_CLEAR: begin
        q_cmd.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::CMD_READ: begin
        q_cmd.op = idx_ok ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        q_cmd.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// ----- src/tcw_fifo.sv -----
`timescale 1ns / 1ps

module tcw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tcw_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::cmd_t    entry_r [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/tcw_back.sv -----
`timescale 1ns / 1ps

module tcw_back #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int STACK_DEPTH = tcw_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  tcw_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::IDX_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::BYTE_W-1:0]  out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]  out_cell_attr
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int STK_AW     = $clog2(STACK_DEPTH);
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int BW         = tcw_pkg::BYTE_W;

  // Sequencer and command.
  tcw_pkg::state_t state_r, state_nxt;
  tcw_pkg::cmd_t   cmd_r, cmd_nxt;

  // Cursor, row offset of the circular screen, and sweep counters.
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;

  // Attribute stack: the top lives in a register, the rest in memory.
  logic [BW-1:0]     top_r, top_nxt;
  logic [CNT_W-1:0]  stk_cnt_r, stk_cnt_nxt;
  logic [CNT_W-1:0]  stk_cnt_m1, stk_cnt_m2;
  logic [BW-1:0]     stk_mem [STACK_DEPTH];
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [BW-1:0]     stk_rdata_r;

  // Screen memory.
  logic [2*BW-1:0]   scr_mem [CELL_COUNT];
  logic              scr_we;
  logic [ADDR_W-1:0] scr_waddr;
  logic [2*BW-1:0]   scr_wdata;
  logic [2*BW-1:0]   scr_rdata_r;

  // Result staging and output register.
  logic [BW-1:0]              res_char_r, res_char_nxt;
  logic [BW-1:0]              res_attr_r, res_attr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [tcw_pkg::IDX_W-1:0]  out_pos_r, out_pos_nxt;
  logic [BW-1:0]              out_char_r, out_char_nxt;
  logic [BW-1:0]              out_attr_r, out_attr_nxt;

  // Address arithmetic.
  logic [ADDR_W-1:0] cur_lin;
  logic [ADDR_W:0]   cur_sum, rd_sum;
  logic [ADDR_W-1:0] cur_phys, rd_phys;
  logic              at_last_col, at_last_row, line_adv, out_free;

  // Logical cursor position and its place in the circular screen.
  assign cur_lin  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign cur_sum  = {1'b0, cur_lin} + {1'b0, base_r};
  assign cur_phys = (cur_sum >= (ADDR_W+1)'(CELL_COUNT))
                    ? ADDR_W'(cur_sum - (ADDR_W+1)'(CELL_COUNT)) : ADDR_W'(cur_sum);
  assign rd_sum   = (ADDR_W+1)'(cmd_r.idx) + {1'b0, base_r};
  assign rd_phys  = (rd_sum >= (ADDR_W+1)'(CELL_COUNT))
                    ? ADDR_W'(rd_sum - (ADDR_W+1)'(CELL_COUNT)) : ADDR_W'(rd_sum);

  assign at_last_col = (col_r == COL_W'(COLUMNS - 1));
  assign at_last_row = (row_r == ROW_W'(ROWS - 1));
  assign line_adv    = ((cmd_r.op == tcw_pkg::OP_WRITE) && at_last_col) ||
                       (cmd_r.op == tcw_pkg::OP_NEWLINE);
  assign out_free    = !out_valid_r || out_ready;

  assign stk_cnt_m1 = stk_cnt_r - CNT_W'(1);
  assign stk_cnt_m2 = stk_cnt_r - CNT_W'(2);
  assign stk_raddr  = stk_cnt_m2[STK_AW-1:0];

  assign init_busy      = (state_r == tcw_pkg::ST_INIT);
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (sweep_cnt_r == '0) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (cmd_r.op)
          tcw_pkg::OP_WRITE, tcw_pkg::OP_NEWLINE: begin
            state_nxt = (line_adv && at_last_row) ? tcw_pkg::ST_FILL : tcw_pkg::ST_DONE;
          end
          tcw_pkg::OP_POP: begin
            state_nxt = (stk_cnt_r > CNT_W'(1)) ? tcw_pkg::ST_POP : tcw_pkg::ST_DONE;
          end
          tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_FILL;
          tcw_pkg::OP_READ:  state_nxt = tcw_pkg::ST_READ;
          default:           state_nxt = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_FILL: begin
        if (sweep_cnt_r == '0) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_POP:  state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE: begin
        if (out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // Datapath and memory strobes for each state.
  always_comb begin
    cmd_nxt        = cmd_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    base_nxt       = base_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    top_nxt        = top_r;
    stk_cnt_nxt    = stk_cnt_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pos_nxt    = out_pos_r;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    q_pop          = 1'b0;
    stk_we         = 1'b0;
    stk_waddr      = stk_cnt_m1[STK_AW-1:0];
    scr_we         = 1'b0;
    scr_waddr      = sweep_addr_r;
    scr_wdata      = {top_r, tcw_pkg::CH_BLANK};
    case (state_r)
      tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
        // Blank one cell per cycle with the top attribute.
        scr_we         = 1'b1;
        sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
        sweep_cnt_nxt  = sweep_cnt_r - ADDR_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
        end
      end
      tcw_pkg::ST_EXEC: begin
        res_char_nxt = '0;
        res_attr_nxt = '0;
        case (cmd_r.op)
          tcw_pkg::OP_WRITE: begin
            scr_we    = 1'b1;
            scr_waddr = cur_phys;
            scr_wdata = {top_r, cmd_r.data};
            if (!at_last_col) col_nxt = col_r + COL_W'(1);
          end
          tcw_pkg::OP_RETURN: col_nxt = '0;
          tcw_pkg::OP_PUSH: begin
            // A full stack overwrites its top entry.
            if (stk_cnt_r < CNT_W'(STACK_DEPTH)) begin
              stk_we      = 1'b1;
              stk_cnt_nxt = stk_cnt_r + CNT_W'(1);
            end
            top_nxt = cmd_r.data;
          end
          tcw_pkg::OP_POP: begin
            if (stk_cnt_r > CNT_W'(1)) stk_cnt_nxt = stk_cnt_m1;
          end
          tcw_pkg::OP_CLEAR: begin
            col_nxt        = '0;
            row_nxt        = '0;
            sweep_addr_nxt = '0;
            sweep_cnt_nxt  = ADDR_W'(CELL_COUNT - 1);
          end
          default: begin
          end
        endcase
        // Move to the next line; off the last row the oldest row is recycled
        // as the new bottom row and blanked.
        if (line_adv) begin
          col_nxt = '0;
          if (at_last_row) begin
            base_nxt = (base_r == ADDR_W'(CELL_COUNT - COLUMNS)) ? '0
                       : base_r + ADDR_W'(COLUMNS);
            sweep_addr_nxt = base_r;
            sweep_cnt_nxt  = ADDR_W'(COLUMNS - 1);
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
      end
      tcw_pkg::ST_POP: top_nxt = stk_rdata_r;
      tcw_pkg::ST_READ: begin
        res_char_nxt = scr_rdata_r[BW-1:0];
        res_attr_nxt = scr_rdata_r[2*BW-1:BW];
      end
      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = tcw_pkg::IDX_W'(cur_lin);
          out_char_nxt  = res_char_r;
          out_attr_nxt  = res_attr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_INIT;
      col_r        <= '0;
      row_r        <= '0;
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_cnt_r  <= ADDR_W'(CELL_COUNT - 1);
      top_r        <= tcw_pkg::RESET_ATTR;
      stk_cnt_r    <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      base_r       <= base_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      top_r        <= top_nxt;
      stk_cnt_r    <= stk_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  // Attribute stack memory: entries below the top.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top_r;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // Screen memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_rdata_r <= scr_mem[rd_phys];
  end

  // The stack never drops below one entry nor grows past its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stk_cnt_r >= CNT_W'(1)) && (stk_cnt_r <= CNT_W'(STACK_DEPTH)))
    else $error("attribute stack count out of range");

  // The cursor stays on the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < (COL_W+1)'(COLUMNS)) && ({1'b0, row_r} < (ROW_W+1)'(ROWS)))
    else $error("cursor off the screen");

  // The row offset always points at the start of a row inside the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, base_r} < (ADDR_W+1)'(CELL_COUNT))
    else $error("row offset out of range");

  // Nothing leaves the queue and no result is offered while the screen is still being initialized.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_INIT) |-> (!q_pop && !out_valid_r))
    else $error("activity during the initial clearing pass");

  // A pop that shrinks the stack enters ST_POP, which reloads the top, on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_EXEC && cmd_r.op == tcw_pkg::OP_POP && stk_cnt_r > CNT_W'(1))
    |=> (state_r == tcw_pkg::ST_POP))
    else $error("pop did not reload the top attribute");

endmodule

// ----- src/text_console_writer.sv -----
`timescale 1ns / 1ps
// Flow: an accepted item passes the queue and the IDLE, EXEC and DONE states into
// the output register; a read, and a pop that shrinks the stack, add READ or POP.
// A put char that leaves the last row adds a sweep that blanks the new bottom row.
// Clear screen adds a sweep over all COLUMNS * ROWS cells, one cell written per cycle.
// The back-end sequencer takes a new item only once it is through with the last one.
// Reset: synchronous; a clearing pass over all COLUMNS * ROWS cells follows, with
// in_ready low, while configuration writes are still taken.

module text_console_writer #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int STACK_DEPTH = tcw_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]    in_command,
  input  logic [tcw_pkg::BYTE_W-1:0]   in_char_code,
  input  logic [tcw_pkg::COLOR_W-1:0]  in_fore_color,
  input  logic [tcw_pkg::COLOR_W-1:0]  in_back_color,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::IDX_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::BYTE_W-1:0]   out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]   out_cell_attr,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);

  tcw_pkg::cmd_t push_cmd, pop_cmd;
  logic          q_push, q_pop, q_full, q_empty, init_busy;

  // Front: configuration and item classification.
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_char_code  (in_char_code),
    .in_fore_color (in_fore_color),
    .in_back_color (in_back_color),
    .in_cell_index (in_cell_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .init_busy     (init_busy),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Queue between the front and the back.
  tcw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back: screen, cursor and attribute stack.
  tcw_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr)
  );

endmodule
